@@ rtl/tksd_pkg.sv @@
// package: constants, command type and key mapping functions of the terminal key decoder
`default_nettype none
package tksd_pkg;

	localparam int MaxSeqBytes = 30;
	localparam int SeqDepth    = MaxSeqBytes + 1;
	localparam int AddrW       = $clog2(SeqDepth);
	localparam int LenW        = $clog2(SeqDepth + 1);
	localparam int QDepth      = 2;
	localparam int QPtrW       = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW       = $clog2(QDepth + 1);

	localparam logic CmdByte    = 1'b0;
	localparam logic CmdTimeout = 1'b1;

	localparam logic [7:0] ByteNul     = 8'h00;
	localparam logic [7:0] ByteBs      = 8'h08;
	localparam logic [7:0] ByteTab     = 8'h09;
	localparam logic [7:0] ByteLf      = 8'h0a;
	localparam logic [7:0] ByteCr      = 8'h0d;
	localparam logic [7:0] ByteCtrlEnd = 8'h1a;
	localparam logic [7:0] ByteEsc     = 8'h1b;
	localparam logic [7:0] ByteSpace   = 8'h20;
	localparam logic [7:0] ByteZero    = 8'h30;
	localparam logic [7:0] ByteNine    = 8'h39;
	localparam logic [7:0] ByteSemi    = 8'h3b;
	localparam logic [7:0] ByteFinLo   = 8'h40;
	localparam logic [7:0] ByteUpA     = 8'h41;
	localparam logic [7:0] ByteUpD     = 8'h44;
	localparam logic [7:0] ByteUpF     = 8'h46;
	localparam logic [7:0] ByteUpH     = 8'h48;
	localparam logic [7:0] ByteSs3     = 8'h4f;
	localparam logic [7:0] ByteUpP     = 8'h50;
	localparam logic [7:0] ByteUpS     = 8'h53;
	localparam logic [7:0] ByteUpZ     = 8'h5a;
	localparam logic [7:0] ByteCsi     = 8'h5b;
	localparam logic [7:0] ByteLowA    = 8'h61;
	localparam logic [7:0] ByteFinHi   = 8'h7e;
	localparam logic [7:0] ByteDel     = 8'h7f;

	localparam logic [7:0] VtHome     = 8'd1;
	localparam logic [7:0] VtDelete   = 8'd3;
	localparam logic [7:0] VtEnd      = 8'd4;
	localparam logic [7:0] VtPageUp   = 8'd5;
	localparam logic [7:0] VtPageDown = 8'd6;
	localparam logic [7:0] VtHomeAlt  = 8'd7;
	localparam logic [7:0] VtEndAlt   = 8'd8;

	localparam logic [3:0] KindChar  = 4'd0;
	localparam logic [3:0] KindBksp  = 4'd1;
	localparam logic [3:0] KindEnter = 4'd2;
	localparam logic [3:0] KindTab   = 4'd3;
	localparam logic [3:0] KindEsc   = 4'd4;
	localparam logic [3:0] KindUp    = 4'd5;
	localparam logic [3:0] KindHome  = 4'd9;
	localparam logic [3:0] KindEnd   = 4'd10;
	localparam logic [3:0] KindDel   = 4'd11;
	localparam logic [3:0] KindPgUp  = 4'd12;
	localparam logic [3:0] KindPgDn  = 4'd13;
	localparam logic [3:0] KindFn    = 4'd14;
	localparam logic [3:0] KindRaw   = 4'd15;

	localparam logic [2:0] ModNone  = 3'b000;
	localparam logic [2:0] ModShift = 3'b001;
	localparam logic [2:0] ModAlt   = 3'b010;
	localparam logic [2:0] ModCtrl  = 3'b100;

	typedef logic [AddrW-1:0] addr_t;
	typedef logic [LenW-1:0]  len_t;

	typedef struct packed {
		logic       is_raw;
		logic [3:0] kind;
		logic [7:0] char_code;
		logic [4:0] fn_number;
		logic [2:0] mods;
		len_t       len;
	} cmd_t;

	function automatic cmd_t key_cmd(input logic [3:0] kind, input logic [7:0] ch,
		input logic [4:0] fn, input logic [2:0] mods);
		cmd_t r;
		r.is_raw    = 1'b0;
		r.kind      = kind;
		r.char_code = ch;
		r.fn_number = fn;
		r.mods      = mods;
		r.len       = '0;
		return r;
	endfunction

	function automatic cmd_t raw_cmd(input len_t n);
		cmd_t r;
		r.is_raw    = 1'b1;
		r.kind      = KindRaw;
		r.char_code = 8'd0;
		r.fn_number = 5'd0;
		r.mods      = ModNone;
		r.len       = n;
		return r;
	endfunction

	function automatic cmd_t char_key(input logic [7:0] c, input logic [2:0] mods);
		cmd_t r;
		if (c inside {ByteDel, ByteBs}) begin
			r = key_cmd(KindBksp, 8'd0, 5'd0, mods);
		end else if (c inside {ByteCr, ByteLf}) begin
			r = key_cmd(KindEnter, 8'd0, 5'd0, mods);
		end else if (c == ByteTab) begin
			r = key_cmd(KindTab, 8'd0, 5'd0, mods);
		end else if (c inside {[8'd1 : ByteCtrlEnd - 8'd1]}) begin
			r = key_cmd(KindChar, ByteLowA + c - 8'd1, 5'd0, mods | ModCtrl);
		end else if (c == ByteNul) begin
			r = key_cmd(KindChar, ByteSpace, 5'd0, mods);
		end else begin
			r = key_cmd(KindChar, c, 5'd0, mods);
		end
		return r;
	endfunction

	function automatic logic [4:0] vt_fn(input logic [7:0] code);
		logic [7:0] t;
		t = 8'd0;
		if (code inside {[8'd11 : 8'd15]}) t = code - 8'd10;
		else if (code inside {[8'd17 : 8'd21]}) t = code - 8'd11;
		else if (code inside {[8'd23 : 8'd26]}) t = code - 8'd12;
		else if (code inside {[8'd28 : 8'd29]}) t = code - 8'd13;
		else if (code inside {[8'd31 : 8'd34]}) t = code - 8'd14;
		return t[4:0];
	endfunction

	function automatic logic [7:0] acc_digit(input logic [7:0] v, input logic [3:0] d);
		logic [11:0] n;
		n = 12'(v) * 12'd10 + 12'(d);
		return (n > 12'd255) ? 8'hff : n[7:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/tksd_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none
module tksd_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/tksd_front.sv @@
// front end: accepts bytes and timeouts, tracks escape sequences and issues key commands
`default_nettype none
module tksd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           cmd,
	input  logic [7:0]     data_byte,
	input  logic           q_full,
	output logic           q_push,
	output tksd_pkg::cmd_t q_data,
	output logic           ram_we,
	output tksd_pkg::addr_t ram_waddr,
	output logic [7:0]     ram_wdata,
	input  logic           replay_done
);
	import tksd_pkg::*;

	localparam logic [1:0] PhIdle    = 2'd0;
	localparam logic [1:0] PhEsc     = 2'd1;
	localparam logic [1:0] PhCollect = 2'd2;

	logic [1:0] phase_q;
	logic       is_ss3_q;
	len_t       seq_len_q;
	logic [7:0] first_q;
	logic       first_bad_q;
	logic [7:0] second_q;
	logic       second_bad_q;
	logic [1:0] sep_cnt_q;
	logic       second_present_q;
	logic       raw_busy_q;

	logic       accept;
	logic       is_fin;
	logic       is_digit;
	logic       is_start;
	logic       at_limit;
	len_t       new_len;
	logic [7:0] mcode;
	logic [7:0] mcode_m1;
	logic [7:0] kcode;
	logic [2:0] mods;
	logic [7:0] off;
	logic [4:0] vfn;
	cmd_t       dec_cmd;

	assign in_ready = !q_full && !raw_busy_q;
	assign accept   = in_valid && in_ready;
	assign is_fin   = data_byte inside {[ByteFinLo : ByteFinHi]};
	assign is_digit = data_byte inside {[ByteZero : ByteNine]};
	assign is_start = data_byte inside {ByteCsi, ByteSs3};
	assign at_limit = seq_len_q >= len_t'(MaxSeqBytes);
	assign new_len  = seq_len_q + len_t'(1);

	// sequence decode at the final byte
	always_comb begin
		mcode    = second_present_q ? (second_bad_q ? 8'd0 : second_q) : 8'd1;
		mcode_m1 = mcode - 8'd1;
		mods     = (mcode inside {[8'd2 : 8'd8]}) ? mcode_m1[2:0] : ModNone;
		kcode    = first_bad_q ? 8'd0 : first_q;
		vfn      = vt_fn(kcode);
		off      = 8'd0;
		dec_cmd  = raw_cmd(new_len);
		if (data_byte inside {[ByteUpP : ByteUpS]}) begin
			off     = data_byte - ByteUpP + 8'd1;
			dec_cmd = key_cmd(KindFn, 8'd0, off[4:0], mods);
		end else if (data_byte == ByteUpF) begin
			dec_cmd = key_cmd(KindEnd, 8'd0, 5'd0, mods);
		end else if (data_byte == ByteUpH) begin
			dec_cmd = key_cmd(KindHome, 8'd0, 5'd0, mods);
		end else if (data_byte inside {[ByteUpA : ByteUpD]}) begin
			off     = data_byte - ByteUpA;
			dec_cmd = key_cmd(KindUp + off[3:0], 8'd0, 5'd0, mods);
		end else if (!is_ss3_q) begin
			if (data_byte == ByteUpZ) begin
				dec_cmd = key_cmd(KindTab, 8'd0, 5'd0, ModShift);
			end else if (data_byte == ByteFinHi) begin
				if (kcode inside {VtHome, VtHomeAlt}) begin
					dec_cmd = key_cmd(KindHome, 8'd0, 5'd0, mods);
				end else if (kcode == VtDelete) begin
					dec_cmd = key_cmd(KindDel, 8'd0, 5'd0, mods);
				end else if (kcode inside {VtEnd, VtEndAlt}) begin
					dec_cmd = key_cmd(KindEnd, 8'd0, 5'd0, mods);
				end else if (kcode == VtPageUp) begin
					dec_cmd = key_cmd(KindPgUp, 8'd0, 5'd0, mods);
				end else if (kcode == VtPageDown) begin
					dec_cmd = key_cmd(KindPgDn, 8'd0, 5'd0, mods);
				end else if (vfn != 5'd0) begin
					dec_cmd = key_cmd(KindFn, 8'd0, vfn, mods);
				end
			end
		end
	end

	always_comb begin
		q_push    = 1'b0;
		q_data    = raw_cmd(seq_len_q);
		ram_we    = 1'b0;
		ram_waddr = seq_len_q[AddrW-1:0];
		ram_wdata = data_byte;
		if (accept) begin
			if (cmd == CmdTimeout) begin
				if (phase_q == PhEsc) begin
					q_push = 1'b1;
					q_data = key_cmd(KindEsc, 8'd0, 5'd0, ModNone);
				end else if (phase_q == PhCollect) begin
					q_push = 1'b1;
				end
			end else begin
				case (phase_q)
					PhEsc: begin
						if (is_start) begin
							ram_we    = 1'b1;
							ram_waddr = '0;
						end else begin
							q_push = 1'b1;
							q_data = char_key(data_byte, ModAlt);
						end
					end
					PhCollect: begin
						ram_we = 1'b1;
						if (is_fin) begin
							q_push = 1'b1;
							q_data = dec_cmd;
						end else if (at_limit) begin
							q_push = 1'b1;
							q_data = raw_cmd(new_len);
						end
					end
					default: begin
						if (data_byte != ByteEsc) begin
							q_push = 1'b1;
							q_data = char_key(data_byte, ModNone);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PhIdle;
			is_ss3_q         <= 1'b0;
			seq_len_q        <= '0;
			first_q          <= 8'd0;
			first_bad_q      <= 1'b0;
			second_q         <= 8'd0;
			second_bad_q     <= 1'b0;
			sep_cnt_q        <= 2'd0;
			second_present_q <= 1'b0;
			raw_busy_q       <= 1'b0;
		end else begin
			if (replay_done) begin
				raw_busy_q <= 1'b0;
			end
			if (q_push && q_data.is_raw) begin
				raw_busy_q <= 1'b1;
			end
			if (accept) begin
				if (cmd == CmdTimeout) begin
					phase_q <= PhIdle;
				end else begin
					case (phase_q)
						PhEsc: begin
							if (is_start) begin
								phase_q          <= PhCollect;
								is_ss3_q         <= (data_byte == ByteSs3);
								seq_len_q        <= len_t'(1);
								first_q          <= 8'd0;
								first_bad_q      <= 1'b0;
								second_q         <= 8'd0;
								second_bad_q     <= 1'b0;
								sep_cnt_q        <= 2'd0;
								second_present_q <= 1'b0;
							end else begin
								phase_q <= PhIdle;
							end
						end
						PhCollect: begin
							seq_len_q <= new_len;
							if (is_fin || at_limit) begin
								phase_q <= PhIdle;
							end else begin
								if (sep_cnt_q != 2'd0) begin
									second_present_q <= 1'b1;
								end
								if (data_byte == ByteSemi) begin
									if (sep_cnt_q != 2'd3) begin
										sep_cnt_q <= sep_cnt_q + 2'd1;
									end
								end else if (sep_cnt_q == 2'd0) begin
									if (is_digit) first_q <= acc_digit(first_q, data_byte[3:0]);
									else first_bad_q <= 1'b1;
								end else if (sep_cnt_q == 2'd1) begin
									if (is_digit) second_q <= acc_digit(second_q, data_byte[3:0]);
									else second_bad_q <= 1'b1;
								end
							end
						end
						default: begin
							phase_q <= (data_byte == ByteEsc) ? PhEsc : PhIdle;
						end
					endcase
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PhCollect) |-> (seq_len_q >= len_t'(1) && seq_len_q <= len_t'(MaxSeqBytes)))
		else $error("collect length out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_data.is_raw) |-> (q_data.len != '0 && !raw_busy_q))
		else $error("raw run issued while replay busy or empty");
`endif
endmodule
`default_nettype wire

@@ rtl/tksd_queue.sv @@
// short command queue between front and back end
`default_nettype none
module tksd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tksd_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output tksd_pkg::cmd_t head
);
	import tksd_pkg::*;

	cmd_t             entries_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full  = count_q == QCntW'(QDepth);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
		return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + QCntW'(1);
			else if (pop && !push) count_q <= count_q - QCntW'(1);
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue underflow");
`endif
endmodule
`default_nettype wire

@@ rtl/tksd_back.sv @@
// back end: turns queued commands into key results and replays raw runs from the buffer
`default_nettype none
module tksd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  tksd_pkg::cmd_t  q_head,
	output logic            q_pop,
	output logic            ram_re,
	output tksd_pkg::addr_t ram_raddr,
	input  logic [7:0]      ram_rdata,
	output logic            replay_done,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [3:0]      key_kind,
	output logic [7:0]      char_code,
	output logic [4:0]      fn_number,
	output logic            shift_mod,
	output logic            alt_mod,
	output logic            ctrl_mod,
	output logic            last_of_run
);
	import tksd_pkg::*;

	localparam logic [1:0] BkIdle = 2'd0;
	localparam logic [1:0] BkRead = 2'd1;
	localparam logic [1:0] BkHold = 2'd2;

	logic [1:0] state_q;
	len_t       idx_q;
	len_t       len_q;
	logic       out_valid_q;

	logic out_free;
	logic load_single;
	logic load_raw;
	logic last_byte;

	assign out_free    = !out_valid_q || out_ready;
	assign q_pop       = (state_q == BkIdle) && !q_empty && (q_head.is_raw || out_free);
	assign load_single = q_pop && !q_head.is_raw;
	assign load_raw    = (state_q == BkHold) && out_free;
	assign last_byte   = (idx_q + len_t'(1)) == len_q;
	assign replay_done = load_raw && last_byte;
	assign ram_re      = state_q == BkRead;
	assign ram_raddr   = idx_q[AddrW-1:0];
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BkIdle;
			idx_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_single || load_raw) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				BkIdle: begin
					if (q_pop && q_head.is_raw) begin
						state_q <= BkRead;
						idx_q   <= '0;
						len_q   <= q_head.len;
					end
				end
				BkRead: begin
					state_q <= BkHold;
				end
				BkHold: begin
					if (load_raw) begin
						if (last_byte) begin
							state_q <= BkIdle;
						end else begin
							state_q <= BkRead;
							idx_q   <= idx_q + len_t'(1);
						end
					end
				end
				default: begin
					state_q <= BkIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			key_kind    <= q_head.kind;
			char_code   <= q_head.char_code;
			fn_number   <= q_head.fn_number;
			shift_mod   <= q_head.mods[0];
			alt_mod     <= q_head.mods[1];
			ctrl_mod    <= q_head.mods[2];
			last_of_run <= 1'b1;
		end else if (load_raw) begin
			key_kind    <= KindRaw;
			char_code   <= ram_rdata;
			fn_number   <= 5'd0;
			shift_mod   <= 1'b0;
			alt_mod     <= 1'b0;
			ctrl_mod    <= 1'b0;
			last_of_run <= last_byte;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BkIdle) |-> (idx_q < len_q))
		else $error("replay index past run length");
`endif
endmodule
`default_nettype wire

@@ rtl/terminal_key_sequence_decoder_unit.sv @@
// top level of the terminal key sequence decoder
// Input channel (in_valid/in_ready) takes one item per transfer: cmd 0 carries a
// received byte in data_byte, cmd 1 is a read timeout. Output channel
// (out_valid/out_ready) gives one decoded key per transfer with key_kind,
// char_code, fn_number, the three modifier flags and last_of_run.
// An item that yields a single key passes a two-entry command queue between the
// parser and the output stage, then the output register; such items can be taken
// every cycle while in_ready is high; the queue absorbs short output stalls.
// An unknown or cut-off escape sequence is replayed as a raw run of up to 31
// bytes read back from the sequence buffer ram; each replayed byte goes through
// a ram read and then an output load, and in_ready stays low from the item that
// starts the run until its last byte reaches the output register.
// While out_ready is low the output register holds its item, the queue fills and
// in_ready drops once the queue is full; nothing is lost.
// Reset (arst_n low) returns the parser to idle, empties the queue and clears
// out_valid; the buffer ram is not cleared and needs no clearing pass.
`default_nettype none
module terminal_key_sequence_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] key_kind,
	output logic [7:0] char_code,
	output logic [4:0] fn_number,
	output logic       shift_mod,
	output logic       alt_mod,
	output logic       ctrl_mod,
	output logic       last_of_run
);
	import tksd_pkg::*;

	logic       q_push;
	cmd_t       q_data;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	cmd_t       q_head;
	logic       ram_we;
	addr_t      ram_waddr;
	logic [7:0] ram_wdata;
	logic       ram_re;
	addr_t      ram_raddr;
	logic [7:0] ram_rdata;
	logic       replay_done;

	tksd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.replay_done (replay_done)
	);

	tksd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	tksd_ram #(
		.Width (8),
		.Depth (SeqDepth)
	) u_seq_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tksd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.replay_done (replay_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_kind    (key_kind),
		.char_code   (char_code),
		.fn_number   (fn_number),
		.shift_mod   (shift_mod),
		.alt_mod     (alt_mod),
		.ctrl_mod    (ctrl_mod),
		.last_of_run (last_of_run)
	);
endmodule
`default_nettype wire
